@@ hdl/nkc_pkg.sv @@
// Shared constants, bus types and kernel placement helper for the normalized convolution block.
package nkc_pkg;

    // Pixel and window geometry.
    localparam int PIXEL_BITS       = 16;
    localparam int MAX_KERNEL_DIM   = 5;
    localparam int SMALL_KERNEL_DIM = 3;
    localparam int WIN_DIM          = 5;
    localparam int WIN_COUNT        = WIN_DIM * WIN_DIM;
    localparam int WIN_CENTER       = WIN_DIM / 2;
    localparam int SLOT_BITS        = 16;
    localparam int IN_BITS          = WIN_COUNT * SLOT_BITS;

    // Arithmetic widths.
    localparam int COEFF_BITS = 8;
    localparam int PROD_BITS  = PIXEL_BITS + COEFF_BITS;
    localparam int ROW_BITS   = PROD_BITS + 3;
    localparam int SUM_BITS   = PROD_BITS + 5;
    localparam int MAG_BITS   = SUM_BITS - 1;
    localparam int WROW_BITS  = COEFF_BITS + 3;
    localparam int WSUM_BITS  = COEFF_BITS + 5;
    localparam int DIV_BITS   = WSUM_BITS - 1;
    localparam int OUT_BITS   = 32;

    // Divider: DIV_STEP quotient bits per pipeline stage.
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (MAG_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NQ_BITS    = DIV_STAGES * DIV_STEP;

    // Pipeline depth: multiply, row sums, total, magnitude, divider stages, result.
    localparam int PIPE_STAGES   = 4 + DIV_STAGES + 1;
    localparam int MAX_INFLIGHT  = PIPE_STAGES + 2;
    localparam int INFLIGHT_BITS = $clog2(MAX_INFLIGHT + 1);

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int COEFF_PER_WORD = CFG_DATA_BITS / COEFF_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COEFF_0     = 3'd0,
        CFG_COEFF_1     = 3'd1,
        CFG_COEFF_2     = 3'd2,
        CFG_COEFF_3     = 3'd3,
        CFG_KERNEL_SIZE = 3'd4
    } cfg_index_t;

    localparam logic KERNEL_SMALL = 1'b0;
    localparam logic KERNEL_FULL  = 1'b1;

    typedef logic [WIN_COUNT-1:0][COEFF_BITS-1:0] coeff_set_t;

    typedef struct packed {
        logic                                valid;
        logic [WIN_COUNT-1:0][PROD_BITS-1:0] prod;
        logic [WIN_COUNT-1:0][COEFF_BITS-1:0] wt;
    } prod_bus_t;

    typedef struct packed {
        logic                zero;
        logic                qneg;
        logic [SUM_BITS-1:0] sum;
        logic [DIV_BITS-1:0] den;
        logic [DIV_BITS-1:0] rem;
        logic [NQ_BITS-1:0]  nq;
    } div_work_t;

    typedef struct packed {
        logic      valid;
        div_work_t work;
    } div_bus_t;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic [OUT_BITS-1:0] value;
    } res_bus_t;

    // Coefficient index used by window pixel p for a dim x dim kernel centred
    // on the window, or -1 when the pixel lies outside the kernel.
    function automatic int tap_of(input int p, input int dim);
        int off;
        int r;
        int c;
        int k;
        off = WIN_CENTER - dim / 2;
        r   = p / WIN_DIM - off;
        c   = p % WIN_DIM - off;
        k   = r * dim + c;
        if (r < 0 || c < 0 || r >= dim || c >= dim || k >= WIN_COUNT) begin
            return -1;
        end
        return k;
    endfunction

endpackage

@@ hdl/nkc_mult.sv @@
// First pipeline stage: per-pixel coefficient selection and 25 parallel products.
module nkc_mult (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [nkc_pkg::IN_BITS-1:0] pixels,
    input  nkc_pkg::coeff_set_t        coeffs,
    input  logic                       kernel_size,
    output nkc_pkg::prod_bus_t         out_bus
);

    logic                                                   valid_reg;
    logic [nkc_pkg::WIN_COUNT-1:0][nkc_pkg::PROD_BITS-1:0]  prod_reg;
    logic [nkc_pkg::WIN_COUNT-1:0][nkc_pkg::PROD_BITS-1:0]  prod_next;
    logic [nkc_pkg::WIN_COUNT-1:0][nkc_pkg::COEFF_BITS-1:0] wt_reg;
    logic [nkc_pkg::WIN_COUNT-1:0][nkc_pkg::COEFF_BITS-1:0] wt_next;

    for (genvar g = 0; g < nkc_pkg::WIN_COUNT; g++) begin : g_tap
        localparam int K_FULL  = nkc_pkg::tap_of(g, nkc_pkg::MAX_KERNEL_DIM);
        localparam int K_SMALL = nkc_pkg::tap_of(g, nkc_pkg::SMALL_KERNEL_DIM);

        logic [nkc_pkg::COEFF_BITS-1:0]       w_full;
        logic [nkc_pkg::COEFF_BITS-1:0]       w_small;
        logic [nkc_pkg::PIXEL_BITS-1:0]       pix;
        logic signed [nkc_pkg::PROD_BITS-1:0] prod;

        if (K_FULL >= 0) begin : g_full
            assign w_full = coeffs[K_FULL];
        end else begin : g_full_off
            assign w_full = '0;
        end

        if (K_SMALL >= 0) begin : g_small
            assign w_small = coeffs[K_SMALL];
        end else begin : g_small_off
            assign w_small = '0;
        end

        assign pix  = pixels[g*nkc_pkg::SLOT_BITS +: nkc_pkg::PIXEL_BITS];
        assign wt_next[g] = (kernel_size == nkc_pkg::KERNEL_FULL) ? w_full : w_small;
        // The product always fits the signed product width, so no guard bit is kept.
        assign prod = $signed({1'b0, pix}) * $signed(wt_next[g]);
        assign prod_next[g] = prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            wt_reg   <= wt_next;
        end
    end

    assign out_bus.valid = valid_reg;
    assign out_bus.prod  = prod_reg;
    assign out_bus.wt    = wt_reg;

endmodule

@@ hdl/nkc_sum.sv @@
// Adder stages: row sums, window total and signed magnitudes for the divider.
module nkc_sum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  nkc_pkg::prod_bus_t in_bus,
    output nkc_pkg::div_bus_t  out_bus
);

    logic signed [nkc_pkg::ROW_BITS-1:0]  row_next  [nkc_pkg::WIN_DIM];
    logic signed [nkc_pkg::ROW_BITS-1:0]  row_reg   [nkc_pkg::WIN_DIM];
    logic signed [nkc_pkg::WROW_BITS-1:0] wrow_next [nkc_pkg::WIN_DIM];
    logic signed [nkc_pkg::WROW_BITS-1:0] wrow_reg  [nkc_pkg::WIN_DIM];
    logic signed [nkc_pkg::SUM_BITS-1:0]  sum_next;
    logic signed [nkc_pkg::SUM_BITS-1:0]  sum_reg;
    logic signed [nkc_pkg::WSUM_BITS-1:0] wsum_next;
    logic signed [nkc_pkg::WSUM_BITS-1:0] wsum_reg;
    logic [nkc_pkg::MAG_BITS-1:0]         mag;
    logic [nkc_pkg::SUM_BITS-1:0]         neg_sum;
    logic [nkc_pkg::WSUM_BITS-1:0]        neg_wsum;
    nkc_pkg::div_work_t                   work_next;
    nkc_pkg::div_work_t                   work_reg;
    logic [2:0]                           vld_reg;

    // Stage two: one sum per window row.
    always_comb
    begin
        for (int r = 0; r < nkc_pkg::WIN_DIM; r++)
        begin
            row_next[r]  = '0;
            wrow_next[r] = '0;
            for (int c = 0; c < nkc_pkg::WIN_DIM; c++)
            begin
                row_next[r] = row_next[r] +
                    nkc_pkg::ROW_BITS'($signed(in_bus.prod[r*nkc_pkg::WIN_DIM+c]));
                wrow_next[r] = wrow_next[r] +
                    nkc_pkg::WROW_BITS'($signed(in_bus.wt[r*nkc_pkg::WIN_DIM+c]));
            end
        end
    end

    // Stage three: window totals.
    always_comb
    begin
        sum_next  = '0;
        wsum_next = '0;
        for (int r = 0; r < nkc_pkg::WIN_DIM; r++)
        begin
            sum_next  = sum_next + nkc_pkg::SUM_BITS'(row_reg[r]);
            wsum_next = wsum_next + nkc_pkg::WSUM_BITS'(wrow_reg[r]);
        end
    end

    // Stage four: split into sign and magnitude for the unsigned divider.
    always_comb
    begin
        neg_sum        = -sum_reg;
        neg_wsum       = -wsum_reg;
        mag            = sum_reg[nkc_pkg::SUM_BITS-1] ? neg_sum[nkc_pkg::MAG_BITS-1:0]
                                                      : sum_reg[nkc_pkg::MAG_BITS-1:0];
        work_next.zero = (wsum_reg == '0);
        work_next.qneg = sum_reg[nkc_pkg::SUM_BITS-1] ^ wsum_reg[nkc_pkg::WSUM_BITS-1];
        work_next.sum  = sum_reg;
        work_next.den  = wsum_reg[nkc_pkg::WSUM_BITS-1] ? neg_wsum[nkc_pkg::DIV_BITS-1:0]
                                                        : wsum_reg[nkc_pkg::DIV_BITS-1:0];
        work_next.rem  = '0;
        work_next.nq   = nkc_pkg::NQ_BITS'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_bus.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg  <= row_next;
            wrow_reg <= wrow_next;
            sum_reg  <= sum_next;
            wsum_reg <= wsum_next;
            work_reg <= work_next;
        end
    end

    assign out_bus.valid = vld_reg[2];
    assign out_bus.work  = work_reg;

endmodule

@@ hdl/nkc_div.sv @@
// Pipelined restoring divider with sign fix-up and the zero-weight bypass.
module nkc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  nkc_pkg::div_bus_t in_bus,
    output nkc_pkg::res_bus_t out_bus
);

    nkc_pkg::div_work_t             work_reg  [nkc_pkg::DIV_STAGES];
    nkc_pkg::div_work_t             work_next [nkc_pkg::DIV_STAGES];
    logic [nkc_pkg::DIV_STAGES-1:0] vld_reg;
    logic                           res_valid_reg;
    logic                           res_zero_reg;
    logic [nkc_pkg::OUT_BITS-1:0]   res_value_reg;
    logic [nkc_pkg::OUT_BITS-1:0]   res_value_next;
    logic [nkc_pkg::OUT_BITS-1:0]   quot;
    nkc_pkg::div_work_t             last;

    for (genvar s = 0; s < nkc_pkg::DIV_STAGES; s++) begin : g_stage
        nkc_pkg::div_work_t src;

        if (s == 0) begin : g_first
            assign src = in_bus.work;
        end else begin : g_chain
            assign src = work_reg[s-1];
        end

        // DIV_STEP restoring steps; quotient bits shift in at the bottom of nq.
        always_comb
        begin
            logic [nkc_pkg::DIV_BITS:0]   trial;
            logic [nkc_pkg::DIV_BITS-1:0] r;
            logic [nkc_pkg::NQ_BITS-1:0]  w;
            r = src.rem;
            w = src.nq;
            for (int i = 0; i < nkc_pkg::DIV_STEP; i++)
            begin
                trial = {r, w[nkc_pkg::NQ_BITS-1]};
                w     = {w[nkc_pkg::NQ_BITS-2:0], 1'b0};
                if (trial >= {1'b0, src.den})
                begin
                    trial = trial - {1'b0, src.den};
                    w[0]  = 1'b1;
                end
                r = trial[nkc_pkg::DIV_BITS-1:0];
            end
            work_next[s]     = src;
            work_next[s].rem = r;
            work_next[s].nq  = w;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[s] <= work_next[s];
            end
        end
    end

    assign last = work_reg[nkc_pkg::DIV_STAGES-1];
    assign quot = nkc_pkg::OUT_BITS'(last.nq);

    always_comb
    begin
        if (last.zero)
        begin
            res_value_next = nkc_pkg::OUT_BITS'($signed(last.sum));
        end
        else if (last.qneg)
        begin
            res_value_next = -quot;
        end
        else
        begin
            res_value_next = quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[nkc_pkg::DIV_STAGES-2:0], in_bus.valid};
            res_valid_reg <= vld_reg[nkc_pkg::DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_zero_reg  <= last.zero;
            res_value_reg <= res_value_next;
        end
    end

    assign out_bus.valid = res_valid_reg;
    assign out_bus.zero  = res_zero_reg;
    assign out_bus.value = res_value_reg;

endmodule

@@ hdl/nkc_out.sv @@
// Output register with a skid entry; its fill state stalls the whole pipeline.
module nkc_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nkc_pkg::res_bus_t             in_bus,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [nkc_pkg::OUT_BITS-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          en
);

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_zero_reg;
    logic                         out_zero_next;
    logic [nkc_pkg::OUT_BITS-1:0] out_value_reg;
    logic [nkc_pkg::OUT_BITS-1:0] out_value_next;
    logic                         skid_valid_reg;
    logic                         skid_valid_next;
    logic                         skid_zero_reg;
    logic                         skid_zero_next;
    logic [nkc_pkg::OUT_BITS-1:0] skid_value_reg;
    logic [nkc_pkg::OUT_BITS-1:0] skid_value_next;
    logic                         push;
    logic                         pop;

    assign en   = !skid_valid_reg;
    assign push = in_bus.valid && en;
    assign pop  = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_zero_next   = out_zero_reg;
        out_value_next  = out_value_reg;
        skid_valid_next = skid_valid_reg;
        skid_zero_next  = skid_zero_reg;
        skid_value_next = skid_value_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_zero_next   = skid_zero_reg;
                out_value_next  = skid_value_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_zero_next  = in_bus.zero;
                out_value_next = in_bus.value;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_zero_next  = in_bus.zero;
                skid_value_next = in_bus.value;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_zero_reg   <= out_zero_next;
        out_value_reg  <= out_value_next;
        skid_zero_reg  <= skid_zero_next;
        skid_value_reg <= skid_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_zero_reg;

endmodule

@@ hdl/normalized_kernel_convolution.sv @@
// Top level of the normalized 5x5 / 3x3 convolution block.
//
// Usage: each beat on the s_axis channel carries one 5x5 pixel window of one
// channel, 25 unsigned 16-bit pixels packed row-major with pixel 0 in the low
// bits. The block multiplies the window (or its centred 3x3 part) by signed
// 8-bit coefficients, adds the products, and divides by the coefficient sum,
// truncating toward zero. When the coefficient sum is zero the raw sum is sent
// and m_axis_tuser is raised. Each input beat gives exactly one output beat.
// Throughput is one window per clock while the receiver keeps up. A result
// passes through one multiply stage, two adder stages, a sign/magnitude
// stage, seven divider stages retiring four quotient bits each, and a result
// stage, followed by the output register, before it appears on m_axis.
// The cfg channel writes one register per beat (index 0..2: coefficient words,
// 3: coefficient 24, 4: kernel size); it is always ready and should only be
// used while no windows are in flight. Reset clears the coefficients, selects
// the 5x5 kernel and empties the pipeline. When the receiver stalls, a skid
// entry behind the output register absorbs one more result and then
// s_axis_tready drops, freezing every stage in place until the output drains.
module normalized_kernel_convolution (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: win_pixels_0_3, win_pixels_4_7, win_pixels_8_11,
    // win_pixels_12_15, win_pixels_16_19, win_pixels_20_23, win_pixel_24.
    input  logic [nkc_pkg::IN_BITS-1:0]         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: filtered_value.
    output logic [nkc_pkg::OUT_BITS-1:0]        m_axis_tdata,
    // Fields from bit 0 up: zero_weight_sum.
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nkc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [nkc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    nkc_pkg::coeff_set_t coeff_reg;
    logic                kernel_size_reg;
    logic                en;
    nkc_pkg::prod_bus_t  prod_bus;
    nkc_pkg::div_bus_t   div_bus;
    nkc_pkg::res_bus_t   res_bus;

    // Configuration writes are always accepted; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg       <= '0;
            kernel_size_reg <= nkc_pkg::KERNEL_FULL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nkc_pkg::CFG_COEFF_0:
                begin
                    coeff_reg[nkc_pkg::COEFF_PER_WORD-1:0] <= cfg_data;
                end
                nkc_pkg::CFG_COEFF_1:
                begin
                    coeff_reg[2*nkc_pkg::COEFF_PER_WORD-1:nkc_pkg::COEFF_PER_WORD] <= cfg_data;
                end
                nkc_pkg::CFG_COEFF_2:
                begin
                    coeff_reg[3*nkc_pkg::COEFF_PER_WORD-1:2*nkc_pkg::COEFF_PER_WORD] <=
                        cfg_data;
                end
                nkc_pkg::CFG_COEFF_3:
                begin
                    coeff_reg[nkc_pkg::WIN_COUNT-1] <= cfg_data[nkc_pkg::COEFF_BITS-1:0];
                end
                nkc_pkg::CFG_KERNEL_SIZE:
                begin
                    kernel_size_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid entry is free.
    assign s_axis_tready = en;

    nkc_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .pixels      (s_axis_tdata),
        .coeffs      (coeff_reg),
        .kernel_size (kernel_size_reg),
        .out_bus     (prod_bus)
    );

    nkc_sum u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_bus  (prod_bus),
        .out_bus (div_bus)
    );

    nkc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_bus  (div_bus),
        .out_bus (res_bus)
    );

    nkc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bus   (res_bus),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser[0]),
        .en       (en)
    );

endmodule

@@ hdl/nkc_checker.sv @@
// Port-level checker for the convolution block and its bind to the top level.
module nkc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [nkc_pkg::OUT_BITS-1:0]        m_axis_tdata,
    input logic [0:0]                          m_axis_tuser
);

    logic [nkc_pkg::INFLIGHT_BITS-1:0] cnt_reg;
    logic [nkc_pkg::INFLIGHT_BITS-1:0] cnt_next;
    logic                              in_beat;
    logic                              out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign cnt_next = cnt_reg + nkc_pkg::INFLIGHT_BITS'(in_beat)
                              - nkc_pkg::INFLIGHT_BITS'(out_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Every result beat must belong to a window that was taken earlier.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt_reg != '0)
        else $error("result offered with no window in flight");

    // The pipeline plus output register and skid entry bound the windows in flight.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= nkc_pkg::INFLIGHT_BITS'(nkc_pkg::MAX_INFLIGHT))
        else $error("more windows in flight than the pipeline can hold");

    // The input side only stalls while a result is waiting at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind normalized_kernel_convolution nkc_checker u_nkc_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the normalized 3x3 / 5x5 kernel convolution block.
`timescale 1ns / 1ps

module tb_top;

    import nkc_pkg::*;

    // Run shape. The directed table comes first, then random segments, each
    // with a freshly loaded kernel. The first three segments throttle the
    // receiver, the next three throttle the sender, and the rest run flat out.
    localparam int SEGMENTS       = 10;
    localparam int ITEMS_PER_SEG  = 163;
    localparam int PRESSURE_AT    = 1100;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = PIPE_STAGES + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // One output beat: the filtered value and the zero weight sum flag.
    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                weight_zero;
    } filt_result_t;

    // One row of the directed table: either a register write or a window.
    // Rows with a typed result bypass the predictor.
    typedef struct {
        bit           is_cfg;
        cfg_index_t   idx;
        logic [CFG_DATA_BITS-1:0] word;
        logic [IN_BITS-1:0]       win;
        bit           typed;
        filt_result_t res;
    } plan_row_t;

    // How the random segments fill the kernel taps that are in use.
    typedef enum int {
        MIX_RANDOM,
        MIX_SMALL,
        MIX_BALANCED,
        MIX_EXTREME
    } kernel_mix_t;

    logic                        clk;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_BITS-1:0]          s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]         m_axis_tdata;
    logic [0:0]                  m_axis_tuser;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    cfg_index_t                  cfg_index     = CFG_COEFF_0;
    logic [CFG_DATA_BITS-1:0]    cfg_data      = '0;

    // Shadow of the block's registers, updated when a write beat is taken.
    logic [COEFF_BITS-1:0] kern_coeff [WIN_COUNT] = '{default: '0};
    logic                  kernel_sel = KERNEL_FULL;

    // Results predicted for windows already taken, oldest first.
    filt_result_t pending_results[$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    normalized_kernel_convolution uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Weighted sum of the kernel over the centred part of the window, divided
    // by the coefficient sum with truncation toward zero. A zero coefficient
    // sum passes the raw weighted sum through and raises the flag.
    function automatic filt_result_t convolve_window(input logic [IN_BITS-1:0] win);
        filt_result_t res;
        int           dim;
        int           off;
        int           k;
        int           p;
        int           w;
        longint       pix;
        longint       acc;
        longint       wacc;
        longint       quot;
        dim  = (kernel_sel == KERNEL_FULL) ? MAX_KERNEL_DIM : SMALL_KERNEL_DIM;
        off  = WIN_CENTER - dim / 2;
        acc  = 0;
        wacc = 0;
        for (int r = 0; r < dim; r++)
        begin
            for (int c = 0; c < dim; c++)
            begin
                k    = r * dim + c;
                p    = (r + off) * WIN_DIM + (c + off);
                w    = $signed(kern_coeff[k]);
                pix  = win[p*SLOT_BITS +: PIXEL_BITS];
                wacc += w;
                acc  += pix * w;
            end
        end
        if (wacc == 0)
        begin
            res.value       = acc[OUT_BITS-1:0];
            res.weight_zero = 1'b1;
        end
        else
        begin
            quot            = acc / wacc;
            res.value       = quot[OUT_BITS-1:0];
            res.weight_zero = 1'b0;
        end
        return res;
    endfunction

    // Window with the selected pixels at one level and the rest at zero.
    function automatic logic [IN_BITS-1:0] mask_window(input logic [WIN_COUNT-1:0] sel,
                                                       input logic [SLOT_BITS-1:0] level);
        logic [IN_BITS-1:0] win;
        win = '0;
        for (int p = 0; p < WIN_COUNT; p++)
        begin
            if (sel[p])
            begin
                win[p*SLOT_BITS +: SLOT_BITS] = level;
            end
        end
        return win;
    endfunction

    function automatic logic [IN_BITS-1:0] two_pixel_window(input int pa,
                                                            input logic [SLOT_BITS-1:0] va,
                                                            input int pb,
                                                            input logic [SLOT_BITS-1:0] vb);
        logic [IN_BITS-1:0] win;
        win = '0;
        win[pa*SLOT_BITS +: SLOT_BITS] = va;
        win[pb*SLOT_BITS +: SLOT_BITS] = vb;
        return win;
    endfunction

    // Pixels are mostly random, with black, white and near-black mixed in so
    // that sums land both on the extremes and close to zero.
    function automatic logic [IN_BITS-1:0] random_window();
        logic [IN_BITS-1:0] win;
        int                 pick;
        for (int p = 0; p < WIN_COUNT; p++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       win[p*SLOT_BITS +: SLOT_BITS] = '0;
                1:       win[p*SLOT_BITS +: SLOT_BITS] = '1;
                2:       win[p*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom_range(0, 15));
                default: win[p*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom());
            endcase
        end
        return win;
    endfunction

    function automatic plan_row_t cfg_row(input cfg_index_t idx,
                                          input logic [CFG_DATA_BITS-1:0] word);
        plan_row_t row;
        row        = '{idx: CFG_COEFF_0, default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.word   = word;
        return row;
    endfunction

    function automatic plan_row_t win_row(input logic [IN_BITS-1:0] win, input bit typed,
                                          input logic [OUT_BITS-1:0] value, input bit flag);
        plan_row_t row;
        row                 = '{idx: CFG_COEFF_0, default: '0};
        row.idx             = CFG_COEFF_0;
        row.win             = win;
        row.typed           = typed;
        row.res.value       = value;
        row.res.weight_zero = flag;
        return row;
    endfunction

    // Offers one window, after a random gap, and records the predicted result
    // once the beat is taken. Valid is only lowered inside a gap, so that
    // back-to-back beats keep it high without a second assignment in the step.
    task automatic send_window(input logic [IN_BITS-1:0] win, input bit use_typed,
                               input filt_result_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= win;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (use_typed)
        begin
            pending_results.push_back(typed_res);
        end
        else
        begin
            pending_results.push_back(convolve_window(win));
        end
    endtask

    // Register writes are only issued with nothing in flight.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_COEFF_0, CFG_COEFF_1, CFG_COEFF_2:
                for (int j = 0; j < COEFF_PER_WORD; j++)
                begin
                    kern_coeff[int'(idx) * COEFF_PER_WORD + j] = word[j*COEFF_BITS +: COEFF_BITS];
                end
            CFG_COEFF_3:
                kern_coeff[WIN_COUNT-1] = word[COEFF_BITS-1:0];
            CFG_KERNEL_SIZE:
                kernel_sel = word[0];
            default:
                ;
        endcase
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] coeff_word(input logic [COEFF_BITS-1:0] kt [WIN_COUNT],
                                                            input int base);
        logic [CFG_DATA_BITS-1:0] word;
        for (int j = 0; j < COEFF_PER_WORD; j++)
        begin
            word[j*COEFF_BITS +: COEFF_BITS] = kt[base + j];
        end
        return word;
    endfunction

    // Loads a whole kernel. Taps outside the selected size keep random
    // values so that the block must ignore them.
    task automatic load_kernel(input kernel_mix_t mix, input logic size);
        logic [COEFF_BITS-1:0] kt [WIN_COUNT];
        int                    taps;
        int                    v;
        taps = (size == KERNEL_FULL) ? WIN_COUNT : SMALL_KERNEL_DIM * SMALL_KERNEL_DIM;
        foreach (kt[k])
        begin
            kt[k] = COEFF_BITS'($urandom_range(0, 255));
        end
        case (mix)
            MIX_SMALL:
                for (int k = 0; k < taps; k++)
                begin
                    v     = $urandom_range(0, 8);
                    v     = v - 4;
                    kt[k] = v[COEFF_BITS-1:0];
                end
            MIX_BALANCED:
            begin
                // Opposite pairs make the coefficient sum exactly zero.
                for (int k = 0; k + 1 < taps; k += 2)
                begin
                    v         = $urandom_range(0, 254);
                    v         = v - 127;
                    kt[k]     = v[COEFF_BITS-1:0];
                    v         = -v;
                    kt[k + 1] = v[COEFF_BITS-1:0];
                end
                if (taps % 2 != 0)
                begin
                    kt[taps - 1] = '0;
                end
            end
            MIX_EXTREME:
                for (int k = 0; k < taps; k++)
                begin
                    kt[k] = ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
                end
            default:
                ;
        endcase
        write_reg(CFG_COEFF_0, coeff_word(kt, 0));
        write_reg(CFG_COEFF_1, coeff_word(kt, COEFF_PER_WORD));
        write_reg(CFG_COEFF_2, coeff_word(kt, 2 * COEFF_PER_WORD));
        write_reg(CFG_COEFF_3, CFG_DATA_BITS'(kt[WIN_COUNT-1]));
        write_reg(CFG_KERNEL_SIZE, CFG_DATA_BITS'(size));
        cfg_valid <= 1'b0;
    endtask

    // Output side: checks every result beat against the oldest prediction,
    // then decides tready for the next edge. Once, partway through the
    // unthrottled segments, it holds off for a long stretch so that the
    // pipeline and its skid entry fill and the input stalls.
    initial
    begin : result_side
        filt_result_t want;
        int           got_count;
        int           hold_left;
        bit           held_once;
        got_count = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    note_error($sformatf("result beat %0d arrived with nothing pending",
                                         got_count));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.value)
                    begin
                        note_error($sformatf("beat %0d filtered_value %0d, predicted %0d",
                                             got_count, $signed(m_axis_tdata),
                                             $signed(want.value)));
                    end
                    if (m_axis_tuser[0] !== want.weight_zero)
                    begin
                        note_error($sformatf("beat %0d zero_weight_sum %b, predicted %b",
                                             got_count, m_axis_tuser[0], want.weight_zero));
                    end
                end
                got_count++;
            end
            if (!held_once && got_count == PRESSURE_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Ends the run when no beat of any channel has moved for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("normalized_kernel_convolution verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t plan[$];
        filt_result_t none;

        none = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. After reset every coefficient is zero, so any
        // window gives a zero raw sum with the flag set. Uniform kernels of
        // +127 or -128 on a white window normalize back to full scale.
        plan.push_back(win_row(mask_window('0, '0), 1'b1, 32'd0, 1'b1));
        plan.push_back(win_row(mask_window('1, '1), 1'b1, 32'd0, 1'b1));
        plan.push_back(cfg_row(CFG_COEFF_0, 64'h7F7F7F7F_7F7F7F7F));
        plan.push_back(cfg_row(CFG_COEFF_1, 64'h7F7F7F7F_7F7F7F7F));
        plan.push_back(cfg_row(CFG_COEFF_2, 64'h7F7F7F7F_7F7F7F7F));
        plan.push_back(cfg_row(CFG_COEFF_3, 64'h7F));
        plan.push_back(win_row(mask_window('1, '1), 1'b1, 32'd65535, 1'b0));
        plan.push_back(win_row(mask_window('1, '0), 1'b1, 32'd0, 1'b0));
        plan.push_back(win_row(random_window(), 1'b0, '0, 1'b0));
        plan.push_back(cfg_row(CFG_COEFF_0, 64'h80808080_80808080));
        plan.push_back(cfg_row(CFG_COEFF_1, 64'h80808080_80808080));
        plan.push_back(cfg_row(CFG_COEFF_2, 64'h80808080_80808080));
        plan.push_back(cfg_row(CFG_COEFF_3, 64'h80));
        plan.push_back(win_row(mask_window('1, '1), 1'b1, 32'd65535, 1'b0));
        plan.push_back(win_row(mask_window(25'h1555555, '1), 1'b0, '0, 1'b0));
        // Twelve taps at -128, twelve at +127 and one at +12 balance to a
        // zero sum, so the large raw sums come out unscaled with the flag.
        plan.push_back(cfg_row(CFG_COEFF_1, 64'h7F7F7F7F_80808080));
        plan.push_back(cfg_row(CFG_COEFF_2, 64'h7F7F7F7F_7F7F7F7F));
        plan.push_back(cfg_row(CFG_COEFF_3, 64'h0C));
        plan.push_back(win_row(mask_window('1, '1), 1'b0, '0, 1'b0));
        plan.push_back(win_row(mask_window(25'h0000FFF, '1), 1'b0, '0, 1'b0));
        plan.push_back(win_row(mask_window(25'h1FFF000, '1), 1'b0, '0, 1'b0));
        // The 3x3 kernel must ignore the window border and taps 9 to 24.
        plan.push_back(cfg_row(CFG_KERNEL_SIZE, CFG_DATA_BITS'(KERNEL_SMALL)));
        plan.push_back(win_row(mask_window('1, '1), 1'b0, '0, 1'b0));
        plan.push_back(win_row(mask_window(25'b11111_10001_10001_10001_11111, '1),
                               1'b0, '0, 1'b0));
        plan.push_back(win_row(random_window(), 1'b0, '0, 1'b0));
        // Weights -2 and +5 sum to 3: a negative quotient that must truncate
        // toward zero rather than round down, and a small positive one.
        plan.push_back(cfg_row(CFG_COEFF_0, 64'h00000005_000000FE));
        plan.push_back(cfg_row(CFG_COEFF_1, 64'h0));
        plan.push_back(win_row(two_pixel_window(6, 16'd8, 12, 16'd1), 1'b0, '0, 1'b0));
        plan.push_back(win_row(two_pixel_window(6, 16'd0, 12, 16'd1), 1'b0, '0, 1'b0));
        plan.push_back(cfg_row(CFG_KERNEL_SIZE, CFG_DATA_BITS'(KERNEL_FULL)));
        plan.push_back(win_row(random_window(), 1'b0, '0, 1'b0));

        send_idle_pct = 22;
        recv_idle_pct = 76;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].word);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_window(plan[i].win, plan[i].typed, plan[i].res);
            end
        end

        // Random segments, each with a new kernel mix and size.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 76;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            load_kernel(kernel_mix_t'(seg % 4), (seg % 3 != 0) ? KERNEL_FULL : KERNEL_SMALL);
            repeat (ITEMS_PER_SEG)
            begin
                send_window(random_window(), 1'b0, none);
            end
        end

        // Drain, then give any stray extra beat time to show up.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("normalized_kernel_convolution verification clean");
        end
        else
        begin
            $display("normalized_kernel_convolution verification failed");
        end
        $finish;
    end

endmodule
